@@ src/lwm_pkg.sv @@
// Shared types and constants for the PCM level window meter.
// Widths, register indexes, reset values and the controller/datapath handshake structs.
// No dependencies.
`default_nettype none

package lwm_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int LEVEL_W      = 16;
    localparam int COUNT_W      = 32;
    localparam int ENERGY_W     = 62;
    localparam int WIN_ENERGY_W = 46;
    localparam int WIN_CNT_W    = 16;
    localparam int MS_W         = 31;
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 1;

    // Magnitude compare width covers both the sample magnitude and 16-bit levels
    localparam int CMP_W     = (SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W;
    localparam int SQ_W      = 2 * SAMPLE_BITS;
    localparam int DIV_CNT_W = $clog2(WIN_ENERGY_W + 1);

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_THRESHOLD = 1'd1;

    localparam logic [CFG_W-1:0] WINDOW_LENGTH_RST  = 16'd16000;
    localparam logic [CFG_W-1:0] CLIP_THRESHOLD_RST = 16'd32700;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_FLUSH  = 1'b1;

    typedef struct packed {
        logic load;
        logic square;
        logic accum;
        logic div_start;
        logic close;
        logic emit;
    } lwm_cmd_t;

    typedef struct packed {
        logic close_due;
        logic div_busy;
        logic out_free;
    } lwm_status_t;

endpackage

`default_nettype wire

@@ src/lwm_ifs.sv @@
// Channel interfaces of the PCM level window meter: input words, result words, config writes.
// Depends on lwm_pkg for field widths.
`default_nettype none

interface lwm_item_if;
    logic                                valid;
    logic                                ready;
    logic                                kind;
    logic signed [lwm_pkg::SAMPLE_BITS-1:0] sample;

    modport source (output valid, output kind, output sample, input ready);
    modport sink (input valid, input kind, input sample, output ready);
endinterface

interface lwm_result_if;
    logic                          valid;
    logic                          ready;
    logic [lwm_pkg::LEVEL_W-1:0]   peak_level;
    logic [lwm_pkg::COUNT_W-1:0]   clip_count;
    logic [lwm_pkg::COUNT_W-1:0]   sample_count;
    logic [lwm_pkg::ENERGY_W-1:0]  energy_total;
    logic                          window_closed;
    logic [lwm_pkg::MS_W-1:0]      window_mean_square;
    logic [lwm_pkg::LEVEL_W-1:0]   window_peak;
    logic [lwm_pkg::MS_W-1:0]      quietest_window;
    logic [lwm_pkg::MS_W-1:0]      loudest_window;
    logic [lwm_pkg::COUNT_W-1:0]   windows_closed;

    modport source (
        output valid, input ready,
        output peak_level, output clip_count, output sample_count, output energy_total,
        output window_closed, output window_mean_square, output window_peak,
        output quietest_window, output loudest_window, output windows_closed
    );
    modport sink (
        input valid, output ready,
        input peak_level, input clip_count, input sample_count, input energy_total,
        input window_closed, input window_mean_square, input window_peak,
        input quietest_window, input loudest_window, input windows_closed
    );
endinterface

interface lwm_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lwm_pkg::CFG_IDX_W-1:0]   index;
    logic [lwm_pkg::CFG_W-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ src/lwm_div.sv @@
// Restoring divider for the window mean square, one quotient bit per cycle.
// Depends on lwm_pkg for operand widths.
`default_nettype none

module lwm_div (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic [lwm_pkg::WIN_ENERGY_W-1:0]  dividend,
    input  wire logic [lwm_pkg::WIN_CNT_W-1:0]     divisor,
    output logic                                   busy,
    output logic [lwm_pkg::WIN_ENERGY_W-1:0]       quotient
);
    import lwm_pkg::*;

    logic [WIN_ENERGY_W-1:0] quo_reg, quo_next;
    logic [WIN_CNT_W-1:0]    rem_reg, rem_next;
    logic [WIN_CNT_W-1:0]    dvs_reg;
    logic [DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic [WIN_CNT_W:0]      trial;
    logic [WIN_CNT_W:0]      diff;
    logic                    fits;

    assign trial = {rem_reg, quo_reg[WIN_ENERGY_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = DIV_CNT_W'(WIN_ENERGY_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract when the divisor fits
            rem_next  = fits ? diff[WIN_CNT_W-1:0] : trial[WIN_CNT_W-1:0];
            quo_next  = {quo_reg[WIN_ENERGY_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

@@ src/lwm_dp.sv @@
// Datapath of the PCM level window meter: config registers, level statistics, window
// accumulators, divider and the result register. Depends on lwm_pkg, lwm_ifs, lwm_div.
`default_nettype none

module lwm_dp (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire lwm_pkg::lwm_cmd_t                   cmd,
    output lwm_pkg::lwm_status_t                     status,
    input  wire logic                                kind,
    input  wire logic [lwm_pkg::SAMPLE_BITS-1:0]     sample,
    input  wire logic                                cfg_we,
    input  wire logic [lwm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [lwm_pkg::CFG_W-1:0]           cfg_data,
    lwm_result_if.source                             result
);
    import lwm_pkg::*;

    // captured word and squared magnitude
    logic                    kind_reg;
    logic [SAMPLE_BITS-1:0]  sample_reg;
    logic [SAMPLE_BITS-1:0]  mag_reg;
    logic [SQ_W-1:0]         sq_reg;
    logic [SAMPLE_BITS-1:0]  mag;

    logic [CFG_W-1:0] wl_reg;
    logic [CFG_W-1:0] thr_reg;

    logic [LEVEL_W-1:0]      total_peak_reg, total_peak_next;
    logic [COUNT_W-1:0]      total_clips_reg, total_clips_next;
    logic [COUNT_W-1:0]      total_samples_reg, total_samples_next;
    logic [ENERGY_W-1:0]     total_energy_reg, total_energy_next;
    logic [WIN_CNT_W-1:0]    win_samples_reg, win_samples_next;
    logic [WIN_ENERGY_W-1:0] win_energy_reg, win_energy_next;
    logic [LEVEL_W-1:0]      win_peak_reg, win_peak_next;
    logic [MS_W-1:0]         min_reg, min_next;
    logic [MS_W-1:0]         max_reg, max_next;
    logic [COUNT_W-1:0]      tally_reg, tally_next;
    logic                    closed_reg, closed_next;
    logic [MS_W-1:0]         ms_reg, ms_next;
    logic [LEVEL_W-1:0]      wpk_reg, wpk_next;

    logic                    out_valid_reg;
    logic [LEVEL_W-1:0]      o_peak_reg;
    logic [COUNT_W-1:0]      o_clips_reg;
    logic [COUNT_W-1:0]      o_samples_reg;
    logic [ENERGY_W-1:0]     o_energy_reg;
    logic                    o_closed_reg;
    logic [MS_W-1:0]         o_ms_reg;
    logic [LEVEL_W-1:0]      o_wpk_reg;
    logic [MS_W-1:0]         o_min_reg;
    logic [MS_W-1:0]         o_max_reg;
    logic [COUNT_W-1:0]      o_tally_reg;

    logic [WIN_CNT_W-1:0]    ws_inc;
    logic                    close_due;
    logic [ENERGY_W:0]       en_sum;
    logic [MS_W-1:0]         ms_new;
    logic                    div_busy;
    logic [WIN_ENERGY_W-1:0] div_quo;
    logic                    out_free;

    // two's complement magnitude; the most negative code maps to its unsigned value
    assign mag = sample_reg[SAMPLE_BITS-1] ? (~sample_reg + 1'b1) : sample_reg;

    assign ws_inc    = win_samples_reg + 1'b1;
    assign close_due = (kind_reg == KIND_FLUSH) ? (win_samples_reg != '0)
                                                : ((ws_inc >= wl_reg) && (ws_inc != '0));
    assign en_sum    = {1'b0, total_energy_reg} + (ENERGY_W + 1)'(sq_reg);
    assign ms_new    = div_quo[MS_W-1:0];
    assign out_free  = !out_valid_reg || result.ready;

    lwm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (win_energy_reg),
        .divisor  (win_samples_reg),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    always_comb
    begin
        total_peak_next    = total_peak_reg;
        total_clips_next   = total_clips_reg;
        total_samples_next = total_samples_reg;
        total_energy_next  = total_energy_reg;
        win_samples_next   = win_samples_reg;
        win_energy_next    = win_energy_reg;
        win_peak_next      = win_peak_reg;
        min_next           = min_reg;
        max_next           = max_reg;
        tally_next         = tally_reg;
        closed_next        = closed_reg;
        ms_next            = ms_reg;
        wpk_next           = wpk_reg;

        if (cmd.accum)
        begin
            closed_next = close_due;
            ms_next     = '0;
            wpk_next    = '0;
            if (kind_reg == KIND_SAMPLE)
            begin
                if (CMP_W'(mag_reg) > CMP_W'(total_peak_reg))
                begin
                    total_peak_next = LEVEL_W'(mag_reg);
                end
                if (CMP_W'(mag_reg) > CMP_W'(win_peak_reg))
                begin
                    win_peak_next = LEVEL_W'(mag_reg);
                end
                if ((CMP_W'(mag_reg) >= CMP_W'(thr_reg)) && (total_clips_reg != '1))
                begin
                    total_clips_next = total_clips_reg + 1'b1;
                end
                total_energy_next = en_sum[ENERGY_W] ? '1 : en_sum[ENERGY_W-1:0];
                win_energy_next   = win_energy_reg + WIN_ENERGY_W'(sq_reg);
                if (total_samples_reg != '1)
                begin
                    total_samples_next = total_samples_reg + 1'b1;
                end
                win_samples_next = ws_inc;
            end
        end

        if (cmd.close)
        begin
            ms_next  = ms_new;
            wpk_next = win_peak_reg;
            // first window seeds the quietest value unconditionally
            if ((tally_reg == '0) || (ms_new < min_reg))
            begin
                min_next = ms_new;
            end
            if (ms_new > max_reg)
            begin
                max_next = ms_new;
            end
            if (tally_reg != '1)
            begin
                tally_next = tally_reg + 1'b1;
            end
            win_samples_next = '0;
            win_energy_next  = '0;
            win_peak_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg            <= WINDOW_LENGTH_RST;
            thr_reg           <= CLIP_THRESHOLD_RST;
            total_peak_reg    <= '0;
            total_clips_reg   <= '0;
            total_samples_reg <= '0;
            total_energy_reg  <= '0;
            win_samples_reg   <= '0;
            win_energy_reg    <= '0;
            win_peak_reg      <= '0;
            min_reg           <= '0;
            max_reg           <= '0;
            tally_reg         <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WINDOW_LENGTH:  wl_reg  <= cfg_data;
                    REG_CLIP_THRESHOLD: thr_reg <= cfg_data;
                    default:            ;
                endcase
            end
            total_peak_reg    <= total_peak_next;
            total_clips_reg   <= total_clips_next;
            total_samples_reg <= total_samples_next;
            total_energy_reg  <= total_energy_next;
            win_samples_reg   <= win_samples_next;
            win_energy_reg    <= win_energy_next;
            win_peak_reg      <= win_peak_next;
            min_reg           <= min_next;
            max_reg           <= max_next;
            tally_reg         <= tally_next;
            if (cmd.emit && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg   <= kind;
            sample_reg <= sample;
        end
        if (cmd.square)
        begin
            mag_reg <= mag;
            sq_reg  <= mag * mag;
        end
        closed_reg <= closed_next;
        ms_reg     <= ms_next;
        wpk_reg    <= wpk_next;
        // load the result word only once the previous one has left
        if (cmd.emit && out_free)
        begin
            o_peak_reg    <= total_peak_reg;
            o_clips_reg   <= total_clips_reg;
            o_samples_reg <= total_samples_reg;
            o_energy_reg  <= total_energy_reg;
            o_closed_reg  <= closed_reg;
            o_ms_reg      <= ms_reg;
            o_wpk_reg     <= wpk_reg;
            o_min_reg     <= min_reg;
            o_max_reg     <= max_reg;
            o_tally_reg   <= tally_reg;
        end
    end

    assign status.close_due = close_due;
    assign status.div_busy  = div_busy;
    assign status.out_free  = out_free;

    assign result.valid              = out_valid_reg;
    assign result.peak_level         = o_peak_reg;
    assign result.clip_count         = o_clips_reg;
    assign result.sample_count       = o_samples_reg;
    assign result.energy_total       = o_energy_reg;
    assign result.window_closed      = o_closed_reg;
    assign result.window_mean_square = o_ms_reg;
    assign result.window_peak        = o_wpk_reg;
    assign result.quietest_window    = o_min_reg;
    assign result.loudest_window     = o_max_reg;
    assign result.windows_closed     = o_tally_reg;

endmodule

`default_nettype wire

@@ src/lwm_ctrl.sv @@
// Controller of the PCM level window meter: sequences capture, square, accumulate,
// divide, close and emit. Depends on lwm_pkg for the command and status structs.
`default_nettype none

module lwm_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire lwm_pkg::lwm_status_t  status,
    output lwm_pkg::lwm_cmd_t          cmd
);
    import lwm_pkg::*;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_SQUARE    = 3'd1;
    localparam logic [2:0] S_ACCUM     = 3'd2;
    localparam logic [2:0] S_DIV_START = 3'd3;
    localparam logic [2:0] S_DIV_WAIT  = 3'd4;
    localparam logic [2:0] S_CLOSE     = 3'd5;
    localparam logic [2:0] S_EMIT      = 3'd6;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SQUARE;
                end
            end
            S_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = S_ACCUM;
            end
            S_ACCUM:
            begin
                cmd.accum  = 1'b1;
                state_next = status.close_due ? S_DIV_START : S_EMIT;
            end
            S_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_CLOSE;
                end
            end
            S_CLOSE:
            begin
                cmd.close  = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // hold here while the receiver still holds the previous word
                cmd.emit = 1'b1;
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ src/pcm_level_window_meter_core.sv @@
// PCM level window meter, top level: joins the controller and the datapath.
// Depends on lwm_pkg, lwm_ifs, lwm_ctrl, lwm_dp.
//
// Usage:
//   item   : one word per PCM sample (kind = 0) or a flush of the partial window
//            (kind = 1). Taken on valid && ready.
//   result : exactly one word per item, in order: running peak, clip, sample and
//            energy totals, plus the closed window's mean square, peak and the
//            quietest/loudest window values.
//   cfg    : index 0 writes window_length, index 1 clip_threshold. Always ready;
//            write only while no item is in flight.
// Sequence: an item that closes no window passes the square, accumulate and emit steps
//   before it reaches the result register; the next item is taken only back in idle.
//   A closing item adds the divider load, the restoring divider (one quotient bit per
//   cycle over the 46-bit window energy), a wait state to see it done and the close
//   update.
// Reset: all statistics clear to zero, window_length = 16000, clip_threshold = 32700.
// Stall: the result sits in an output register; the next item is still accepted
//   and processed, and waits in its last step until that register is free.
`default_nettype none

module pcm_level_window_meter_core (
    input  wire logic     clk,
    input  wire logic     rst_n,
    lwm_item_if.sink      item,
    lwm_result_if.source  result,
    lwm_cfg_if.sink       cfg
);
    import lwm_pkg::*;

    lwm_cmd_t    cmd;
    lwm_status_t status;
    logic        in_ready;

    assign item.ready = in_ready;
    assign cfg.ready  = 1'b1;

    lwm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    lwm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .kind      (item.kind),
        .sample    (item.sample),
        .cfg_we    (cfg.valid && cfg.ready),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .result    (result)
    );

endmodule

`default_nettype wire

@@ src/lwm_checker.sv @@
// Port-level checks for the PCM level window meter, bound to the top level.
// Depends on lwm_pkg for field widths.
`default_nettype none

module lwm_checker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         out_valid,
    input  wire logic                         out_ready,
    input  wire logic                         window_closed,
    input  wire logic [lwm_pkg::MS_W-1:0]     window_mean_square,
    input  wire logic [lwm_pkg::LEVEL_W-1:0]  window_peak,
    input  wire logic [lwm_pkg::MS_W-1:0]     quietest_window,
    input  wire logic [lwm_pkg::MS_W-1:0]     loudest_window,
    input  wire logic [lwm_pkg::COUNT_W-1:0]  windows_closed
);
    import lwm_pkg::*;

    // a stalled result word stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped while stalled");

    a_open_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !window_closed |-> (window_mean_square == '0) && (window_peak == '0))
        else $error("window fields nonzero without a close");

    a_loud_over_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> loudest_window >= quietest_window)
        else $error("loudest window below quietest window");

    a_close_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && window_closed |->
            (window_mean_square <= loudest_window) && (window_mean_square >= quietest_window)
            && (windows_closed != '0))
        else $error("closed window outside the quietest/loudest range");

    a_no_window_no_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (windows_closed == '0) |->
            (quietest_window == '0) && (loudest_window == '0))
        else $error("window range set before any window closed");

endmodule

bind pcm_level_window_meter_core lwm_checker u_lwm_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .out_valid          (result.valid),
    .out_ready          (result.ready),
    .window_closed      (result.window_closed),
    .window_mean_square (result.window_mean_square),
    .window_peak        (result.window_peak),
    .quietest_window    (result.quietest_window),
    .loudest_window     (result.loudest_window),
    .windows_closed     (result.windows_closed)
);

`default_nettype wire

@@ sim/lwm_meter_checker.sv @@
// Scoreboard for the PCM level window meter: watches the item, result and config channels.
// Predicts each result word from the accepted items and compares it field by field.
// Depends on lwm_pkg and lwm_ifs.

module lwm_meter_checker import lwm_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    lwm_item_if         item,
    lwm_result_if       result,
    lwm_cfg_if          cfg,
    output int unsigned results_seen,
    output int unsigned windows_seen,
    output int unsigned pending,
    output int unsigned errors
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SHOW_LIMIT = 50;

    typedef struct packed {
        logic [LEVEL_W-1:0]  peak_level;
        logic [COUNT_W-1:0]  clip_count;
        logic [COUNT_W-1:0]  sample_count;
        logic [ENERGY_W-1:0] energy_total;
        logic                window_closed;
        logic [MS_W-1:0]     window_mean_square;
        logic [LEVEL_W-1:0]  window_peak;
        logic [MS_W-1:0]     quietest_window;
        logic [MS_W-1:0]     loudest_window;
        logic [COUNT_W-1:0]  windows_closed;
    } readout_t;

    localparam logic [COUNT_W-1:0]  COUNT_MAX  = '1;
    localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;

    logic [CFG_W-1:0]        win_len;
    logic [CFG_W-1:0]        clip_thr;
    logic [LEVEL_W-1:0]      peak_all;
    logic [LEVEL_W-1:0]      peak_win;
    logic [COUNT_W-1:0]      clips_all;
    logic [COUNT_W-1:0]      samples_all;
    logic [COUNT_W-1:0]      tally;
    logic [ENERGY_W-1:0]     energy_all;
    logic [WIN_CNT_W-1:0]    win_count;
    logic [WIN_ENERGY_W-1:0] win_energy;
    logic [MS_W-1:0]         quietest;
    logic [MS_W-1:0]         loudest;
    readout_t                readout_q[$];

    function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    // Advance the meter by one word and return the readout it produces
    function automatic readout_t next_readout(input logic kind,
                                              input logic signed [SAMPLE_BITS-1:0] smp);
        readout_t   r;
        logic [63:0] mag;
        logic [63:0] sq;
        logic [63:0] ms;
        logic        closing;
        r = '0;
        ms = '0;
        closing = 1'b0;
        if (kind == KIND_SAMPLE)
        begin
            mag = smp[SAMPLE_BITS-1] ? 64'(-longint'(smp)) : 64'(longint'(smp));
            sq = mag * mag;
            if (mag > 64'(peak_all))
                peak_all = mag[LEVEL_W-1:0];
            if (mag > 64'(peak_win))
                peak_win = mag[LEVEL_W-1:0];
            if (mag >= 64'(clip_thr))
                clips_all = bump(clips_all);
            if (sq > 64'(ENERGY_MAX - energy_all))
                energy_all = ENERGY_MAX;
            else
                energy_all = energy_all + sq[ENERGY_W-1:0];
            win_energy = win_energy + sq[WIN_ENERGY_W-1:0];
            samples_all = bump(samples_all);
            win_count = win_count + 1'b1;
            // a length of zero behaves as one
            closing = (win_count != '0) && (win_count >= win_len);
        end
        else
        begin
            closing = (win_count != '0);
        end
        if (closing)
        begin
            ms = 64'(win_energy) / 64'(win_count);
            r.window_mean_square = ms[MS_W-1:0];
            r.window_peak = peak_win;
            // first window replaces the quietest value unconditionally
            if (tally == '0 || ms[MS_W-1:0] < quietest)
                quietest = ms[MS_W-1:0];
            if (ms[MS_W-1:0] > loudest)
                loudest = ms[MS_W-1:0];
            tally = bump(tally);
            win_count = '0;
            win_energy = '0;
            peak_win = '0;
        end
        r.peak_level = peak_all;
        r.clip_count = clips_all;
        r.sample_count = samples_all;
        r.energy_total = energy_all;
        r.window_closed = closing;
        r.quietest_window = quietest;
        r.loudest_window = loudest;
        r.windows_closed = tally;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            errors = errors + 1;
            if (errors <= SHOW_LIMIT)
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
            if (errors == SHOW_LIMIT)
                $display("%0t ns: further mismatches are counted only", $time);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        readout_t want;
        if (!rst_n)
        begin
            win_len = WINDOW_LENGTH_RST;
            clip_thr = CLIP_THRESHOLD_RST;
            peak_all = '0;
            peak_win = '0;
            clips_all = '0;
            samples_all = '0;
            tally = '0;
            energy_all = '0;
            win_count = '0;
            win_energy = '0;
            quietest = '0;
            loudest = '0;
            readout_q.delete();
            errors = 0;
            results_seen <= 0;
            windows_seen <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_WINDOW_LENGTH)
                    win_len = cfg.data;
                else if (cfg.index == REG_CLIP_THRESHOLD)
                    clip_thr = cfg.data;
            end
            if (item.valid && item.ready)
            begin
                want = next_readout(item.kind, item.sample);
                readout_q.push_back(want);
            end
            if (result.valid && result.ready)
            begin
                results_seen <= results_seen + 1;
                if (readout_q.size() == 0)
                begin
                    errors = errors + 1;
                    $display("%0t ns: result word with nothing expected, expected none, actual %h",
                             $time, result.energy_total);
                end
                else
                begin
                    want = readout_q.pop_front();
                    check_field("peak_level", 64'(want.peak_level), 64'(result.peak_level));
                    check_field("clip_count", 64'(want.clip_count), 64'(result.clip_count));
                    check_field("sample_count", 64'(want.sample_count),
                                64'(result.sample_count));
                    check_field("energy_total", 64'(want.energy_total),
                                64'(result.energy_total));
                    check_field("window_closed", 64'(want.window_closed),
                                64'(result.window_closed));
                    check_field("window_mean_square", 64'(want.window_mean_square),
                                64'(result.window_mean_square));
                    check_field("window_peak", 64'(want.window_peak), 64'(result.window_peak));
                    check_field("quietest_window", 64'(want.quietest_window),
                                64'(result.quietest_window));
                    check_field("loudest_window", 64'(want.loudest_window),
                                64'(result.loudest_window));
                    check_field("windows_closed", 64'(want.windows_closed),
                                64'(result.windows_closed));
                    if (want.window_closed)
                        windows_seen <= windows_seen + 1;
                end
            end
            pending <= readout_q.size();
        end
    end

endmodule

@@ sim/pcm_level_window_meter_core_test.sv @@
// Testbench top for pcm_level_window_meter_core: clock, reset, item and config stimulus.
// Depends on lwm_pkg, lwm_ifs, the core and lwm_meter_checker, which does the result checking.

module pcm_level_window_meter_core_test import lwm_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 1400;

    logic        clk;
    logic        rst_n;
    logic        sink_ready = 1'b0;
    logic [15:0] stall_mask = '1;
    logic [3:0]  stall_phase = '0;

    int unsigned words_sent = 0;
    int unsigned flushes_sent = 0;
    int unsigned reg_writes = 0;
    int unsigned results_seen;
    int unsigned windows_seen;
    int unsigned pending;
    int unsigned errors;

    lwm_item_if   item_ch();
    lwm_result_if result_ch();
    lwm_cfg_if    cfg_ch();

    pcm_level_window_meter_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    lwm_meter_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item_ch),
        .result       (result_ch),
        .cfg          (cfg_ch),
        .results_seen (results_seen),
        .windows_seen (windows_seen),
        .pending      (pending),
        .errors       (errors)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Rotate the stall pattern one bit per cycle
    assign result_ch.ready = sink_ready;
    always @(posedge clk)
    begin
        stall_phase <= stall_phase + 1'b1;
        sink_ready <= stall_mask[stall_phase];
    end

    initial
    begin
        #10ms;
        $display("Timeout: results still outstanding");
        $display("Verification failed");
        $finish;
    end

    task automatic send_word(input logic kind, input logic signed [SAMPLE_BITS-1:0] smp);
        item_ch.valid <= 1'b1;
        item_ch.kind <= kind;
        item_ch.sample <= smp;
        @(posedge clk);
        while (item_ch.ready !== 1'b1)
            @(posedge clk);
        words_sent++;
        if (kind == KIND_FLUSH)
            flushes_sent++;
    endtask

    task automatic rest(input int cycles);
        item_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Hold the sender until every result word is back
    task automatic drain();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (results_seen != words_sent)
            @(posedge clk);
    endtask

    // Write both registers back to back; valid stays high across the pair
    task automatic write_regs(input logic [CFG_W-1:0] len, input logic [CFG_W-1:0] thr);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= REG_WINDOW_LENGTH;
        cfg_ch.data <= len;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge clk);
        cfg_ch.index <= REG_CLIP_THRESHOLD;
        cfg_ch.data <= thr;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        reg_writes += 2;
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(input int tone);
        logic signed [SAMPLE_BITS-1:0] s;
        s = SAMPLE_BITS'($urandom());
        case (tone)
            0: s = ($urandom_range(0, 7) == 0) ? SAMPLE_BITS'($urandom_range(0, 6) - 3) : '0;
            1: s = SAMPLE_BITS'($urandom_range(0, 128) - 64);
            2:
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    case ($urandom_range(0, 3))
                        0: s = 16'sh8000;
                        1: s = 16'sh7fff;
                        2: s = 16'sh8001;
                        default: s = -16'sd1;
                    endcase
                end
            end
            default: ;
        endcase
        return s;
    endfunction

    initial
    begin
        int unsigned words_left;
        int unsigned phase_len;
        int unsigned burst;
        int unsigned gap_max;
        int unsigned flush_weight;
        int          tone;
        logic [CFG_W-1:0] len;
        logic [CFG_W-1:0] thr;

        rst_n <= 1'b0;
        item_ch.valid <= 1'b0;
        item_ch.kind <= KIND_SAMPLE;
        item_ch.sample <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_WINDOW_LENGTH;
        cfg_ch.data <= '0;
        stall_mask <= 16'hb6d5;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: extremes, clip edge, flush of a partial window, empty flush
        send_word(KIND_SAMPLE, 16'sd0);
        send_word(KIND_SAMPLE, 16'sh7fff);
        send_word(KIND_SAMPLE, 16'sh8000);
        send_word(KIND_SAMPLE, 16'sd32700);
        send_word(KIND_SAMPLE, 16'sd32699);
        send_word(KIND_SAMPLE, -16'sd1);
        send_word(KIND_SAMPLE, 16'sd1);
        send_word(KIND_FLUSH, 16'sd0);
        send_word(KIND_FLUSH, 16'sh5a5a);

        // Zero length closes on every sample; zero threshold clips everything
        drain();
        write_regs(16'd0, 16'd0);
        send_word(KIND_SAMPLE, 16'sd0);
        send_word(KIND_SAMPLE, -16'sd3);
        send_word(KIND_SAMPLE, 16'sh7fff);

        // Full-scale threshold, then shorten the window below its fill
        drain();
        write_regs(16'd8, 16'd32768);
        send_word(KIND_SAMPLE, 16'sh8000);
        send_word(KIND_SAMPLE, 16'sh7fff);
        send_word(KIND_SAMPLE, 16'sd100);
        send_word(KIND_SAMPLE, -16'sd100);
        send_word(KIND_SAMPLE, 16'sd7);
        drain();
        write_regs(16'd3, 16'd32768);
        send_word(KIND_SAMPLE, 16'sd1);
        send_word(KIND_FLUSH, 16'sd0);

        // Longest window and a threshold nothing reaches
        drain();
        write_regs(16'hffff, 16'hffff);
        send_word(KIND_SAMPLE, 16'sh8000);
        send_word(KIND_SAMPLE, 16'sd12345);
        send_word(KIND_FLUSH, 16'sd0);

        words_left = RANDOM_WORDS;
        while (words_left > 0)
        begin
            drain();
            case ($urandom_range(0, 9))
                0: len = 16'd1;
                1: len = 16'd0;
                2: len = 16'hffff;
                3: len = CFG_W'($urandom_range(200, 400));
                default: len = CFG_W'($urandom_range(2, 40));
            endcase
            case ($urandom_range(0, 5))
                0: thr = 16'd0;
                1: thr = 16'd32768;
                2: thr = 16'hffff;
                default: thr = CFG_W'($urandom_range(0, 32768));
            endcase
            write_regs(len, thr);

            tone = $urandom_range(0, 7);
            flush_weight = $urandom_range(0, 3);
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            stall_mask <= ($urandom_range(0, 3) == 0) ? 16'hffff : (16'($urandom()) | 16'h1);
            phase_len = $urandom_range(40, 160);
            if (phase_len > words_left)
                phase_len = words_left;
            burst = $urandom_range(1, 12);
            repeat (phase_len)
            begin
                if (burst == 0)
                begin
                    if (gap_max != 0)
                        rest($urandom_range(1, gap_max));
                    burst = $urandom_range(1, 12);
                end
                if ($urandom_range(0, 31) < flush_weight)
                    send_word(KIND_FLUSH, SAMPLE_BITS'($urandom()));
                else
                    send_word(KIND_SAMPLE, pick_sample(tone));
                burst--;
            end
            words_left -= phase_len;
        end

        drain();
        // all result words are back; idle on before printing the summary
        repeat (60) @(posedge clk);

        $display("Sent %0d words (%0d flushes) with %0d register writes, lengths 0 to 65535.",
                 words_sent, flushes_sent, reg_writes);
        $display("Checked %0d result words, %0d of them closing a window; %0d mismatches.",
                 results_seen, windows_seen, errors);
        if (errors == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
